@@ rtl/core/crcfb_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfb_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the framer.
// ----------------------------------------------------------------------------
package crcfb_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  SYNC0_BYTE = 8'hEB;
    localparam logic [7:0]  SYNC1_BYTE = 8'hA6;
    localparam logic [7:0]  ZERO_BYTE  = 8'h00;
    localparam logic [7:0]  TERM_BYTE  = 8'h0A;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] MAX_FRAME_RESET = 16'd512;
    localparam logic [16:0] FRAME_OVERHEAD  = 17'd8;
    localparam logic [15:0] LEN_FIELD_ADD   = 16'd3;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        OP_REJECT = 2'd0,
        OP_HEADER = 2'd1,
        OP_DATA   = 2'd2
    } op_kind_t;

    // data: length field for a header, byte in [7:0] for data
    typedef struct packed {
        op_kind_t    kind;
        logic        last;
        logic [15:0] data;
    } op_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/crc_frame_builder.sv @@
// ----------------------------------------------------------------------------
// crc_frame_builder
// Frame: sync, length field, zero byte, payload, terminator, CRC-16/Modbus.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   side band
//  s_*      in   [15:0] payload_length, [23:16] data_byte  tuser: cmd
//  m_*      out  [7:0] frame_byte                         tlast: end_of_frame,
//                                                         tuser: rejected
//  cfg_*    in   cfg_wr_data: max_frame_bytes             cfg_wr_en: write
//
//  Output side runs one word per cycle while m_tready is high and ops wait;
//  a frame of L payload bytes is L + 8 words, input L + 1, paced by the back end.
//  From idle, a start word reaches m_tvalid via queue, step_reg and out regs.
//  A four-entry op queue lets input run ahead while headers expand.
//  Reset clears queue, counters and output valid; max_frame_bytes resets to 512.
//  s_tready drops only while the queue is full; m_tready stalls hold the word.
// ----------------------------------------------------------------------------
module crc_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // payload_length, data_byte
    input  logic        s_tuser,    // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // frame_byte
    output logic        m_tlast,
    output logic        m_tuser,    // rejected
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import crcfb_pkg::*;

    logic push_valid, queue_full, queue_empty, pop;
    op_t  push_op, head_op;

    crcfb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .queue_full  (queue_full),
        .push_valid  (push_valid),
        .push_op     (push_op)
    );

    crcfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_op    (push_op),
        .full       (queue_full),
        .pop        (pop),
        .head_op    (head_op),
        .empty      (queue_empty)
    );

    crcfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_op     (head_op),
        .queue_empty (queue_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

@@ rtl/core/crcfb_front.sv @@
// ----------------------------------------------------------------------------
// crcfb_front
// Accepts input words, checks the frame size and tracks the payload count.
// ----------------------------------------------------------------------------
module crcfb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               queue_full,
    output logic               push_valid,
    output crcfb_pkg::op_t     push_op
);
    import crcfb_pkg::*;

    logic [15:0] max_frame_reg;
    logic        active_reg, active_next;
    logic [15:0] remain_reg, remain_next;

    logic        accept;
    logic [15:0] len;
    logic [7:0]  data_byte;

    assign s_tready  = !queue_full;
    assign accept    = s_tvalid && s_tready;
    assign len       = s_tdata[15:0];
    assign data_byte = s_tdata[23:16];

    always_comb
    begin
        active_next = active_reg;
        remain_next = remain_reg;
        push_valid  = 1'b0;
        push_op     = '{kind: OP_REJECT, last: 1'b0, data: 16'h0000};
        if (accept)
        begin
            if (s_tuser == CMD_START)
            begin
                active_next = 1'b0;
                remain_next = 16'h0000;
                push_valid  = 1'b1;
                if (({1'b0, len} + FRAME_OVERHEAD) > {1'b0, max_frame_reg})
                begin
                    push_op = '{kind: OP_REJECT, last: 1'b1, data: 16'h0000};
                end
                else
                begin
                    push_op = '{kind: OP_HEADER, last: (len == 16'h0000),
                                data: len + LEN_FIELD_ADD};
                    if (len != 16'h0000)
                    begin
                        active_next = 1'b1;
                        remain_next = len;
                    end
                end
            end
            else if (active_reg)
            begin
                push_valid  = 1'b1;
                push_op     = '{kind: OP_DATA, last: (remain_reg == 16'd1),
                                data: {8'h00, data_byte}};
                remain_next = remain_reg - 16'd1;
                if (remain_reg == 16'd1)
                    active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= MAX_FRAME_RESET;
            active_reg    <= 1'b0;
            remain_reg    <= 16'h0000;
        end
        else
        begin
            if (cfg_wr_en)
                max_frame_reg <= cfg_wr_data;
            active_reg <= active_next;
            remain_reg <= remain_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !queue_full)
        else $error("push into full queue");

    a_active_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> remain_reg != 16'h0000)
        else $error("active frame with zero count");

    a_payload_idle_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser == CMD_PAYLOAD && !active_reg |-> !push_valid)
        else $error("payload pushed while idle");

endmodule

@@ rtl/core/crcfb_queue.sv @@
// ----------------------------------------------------------------------------
// crcfb_queue
// Small FIFO of decoded operations between front and back.
// ----------------------------------------------------------------------------
module crcfb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  crcfb_pkg::op_t     push_op,
    output logic               full,
    input  logic               pop,
    output crcfb_pkg::op_t     head_op,
    output logic               empty
);
    import crcfb_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = entry_reg[rd_ptr_reg];
    assign do_push = push_valid && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

@@ rtl/core/crcfb_back.sv @@
// ----------------------------------------------------------------------------
// crcfb_back
// Expands queued operations into frame bytes and keeps the running CRC.
// ----------------------------------------------------------------------------
module crcfb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  crcfb_pkg::op_t     head_op,
    input  logic               queue_empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);
    import crcfb_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SYNC0 = 11'b00000000010,
        S_SYNC1 = 11'b00000000100,
        S_LENHI = 11'b00000001000,
        S_LENLO = 11'b00000010000,
        S_ZERO  = 11'b00000100000,
        S_PAY   = 11'b00001000000,
        S_TERM  = 11'b00010000000,
        S_CRCLO = 11'b00100000000,
        S_CRCHI = 11'b01000000000,
        S_REJ   = 11'b10000000000
    } step_t;

    step_t       step_reg, step_next;
    op_t         op_reg;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg, out_rej_reg;

    logic        out_free, emit, done, feed;
    logic [7:0]  step_byte;
    logic        step_last, step_rej;
    step_t       succ, start_step;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = (step_reg != S_IDLE) && out_free;
    assign pop      = !queue_empty && ((step_reg == S_IDLE) || (emit && done));

    always_comb
    begin
        unique case (head_op.kind)
            OP_REJECT: start_step = S_REJ;
            OP_HEADER: start_step = S_SYNC0;
            OP_DATA:   start_step = S_PAY;
            default:   start_step = S_REJ;
        endcase
    end

    always_comb
    begin
        step_byte = ZERO_BYTE;
        step_last = 1'b0;
        step_rej  = 1'b0;
        feed      = 1'b0;
        done      = 1'b0;
        succ      = S_IDLE;
        unique case (step_reg)
            S_IDLE:  done = 1'b1;
            S_SYNC0: begin step_byte = SYNC0_BYTE; feed = 1'b1; succ = S_SYNC1; end
            S_SYNC1: begin step_byte = SYNC1_BYTE; feed = 1'b1; succ = S_LENHI; end
            S_LENHI: begin step_byte = op_reg.data[15:8]; feed = 1'b1; succ = S_LENLO; end
            S_LENLO: begin step_byte = op_reg.data[7:0]; feed = 1'b1; succ = S_ZERO; end
            S_ZERO:
            begin
                step_byte = ZERO_BYTE;
                feed      = 1'b1;
                succ      = S_TERM;
                done      = !op_reg.last;
            end
            S_PAY:
            begin
                step_byte = op_reg.data[7:0];
                feed      = 1'b1;
                succ      = S_TERM;
                done      = !op_reg.last;
            end
            S_TERM:  begin step_byte = TERM_BYTE; feed = 1'b1; succ = S_CRCLO; end
            S_CRCLO: begin step_byte = crc_reg[7:0]; succ = S_CRCHI; end
            S_CRCHI:
            begin
                step_byte = crc_reg[15:8];
                step_last = 1'b1;
                done      = 1'b1;
            end
            S_REJ:
            begin
                step_last = 1'b1;
                step_rej  = 1'b1;
                done      = 1'b1;
            end
            default: done = 1'b1;
        endcase
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (emit && feed)
            crc_next = crc_feed((step_reg == S_SYNC0) ? CRC_INIT : crc_reg, step_byte);

        if (emit && !done)
            step_next = succ;
        else if ((step_reg == S_IDLE) || emit)
            step_next = pop ? start_step : S_IDLE;
        else
            step_next = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            crc_reg  <= crc_next;
            if (out_free)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            op_reg <= head_op;
        if (emit)
        begin
            out_byte_reg <= step_byte;
            out_last_reg <= step_last;
            out_rej_reg  <= step_rej;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_rej_reg;

    a_reject_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == ZERO_BYTE)
        else $error("reject word malformed");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty)
        else $error("pop from empty queue");

    a_crc_hi_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit && step_reg == S_CRCHI |=> m_tvalid && m_tlast && !m_tuser)
        else $error("final CRC byte not marked last");

endmodule

@@ tb/tb_crc_frame_builder.sv @@
// ----------------------------------------------------------------------------
// tb_crc_frame_builder
// Self-checking bench for the CRC-16/Modbus frame builder. Words are driven
// into the stream input and the same words feed a behavioral copy of the
// framer. It builds the expected header, payload, terminator and CRC bytes,
// or a reject word. Every output word is compared against that list in
// order. Directed cases cover size limits, empty frames, aborts and stray
// payload. Random traffic follows, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_crc_frame_builder;
    timeunit 1ns;
    timeprecision 1ps;
    import crcfb_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 300;
    localparam int TAIL_WORDS     = 40;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       rej;
    } frame_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    frame_word_t expected_bytes[$];
    logic [15:0] limit_reg   = MAX_FRAME_RESET;
    logic [15:0] crc_acc     = CRC_INIT;
    logic [15:0] bytes_left  = '0;
    logic        frame_open  = 1'b0;
    int          busy_words  = 0;
    int          mismatches  = 0;
    int          idle_cycles = 0;
    bit          no_idle     = 1'b0;
    bit          stall_sink  = 1'b0;

    crc_frame_builder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------- frame predictor ----------------

    function automatic logic [15:0] crc_after(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c;
        for (int i = 0; i < 8; i++)
            r = (r[0] ^ b[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic push_word(input logic [7:0] data, input logic last, input logic rej);
        frame_word_t w;
        w.data = data;
        w.last = last;
        w.rej  = rej;
        expected_bytes.push_back(w);
    endtask

    task automatic emit_byte(input logic [7:0] b);
        crc_acc = crc_after(crc_acc, b);
        push_word(b, 1'b0, 1'b0);
    endtask

    task automatic close_frame();
        emit_byte(TERM_BYTE);
        push_word(crc_acc[7:0], 1'b0, 1'b0);
        push_word(crc_acc[15:8], 1'b1, 1'b0);
        frame_open = 1'b0;
    endtask

    task automatic model_word(input logic cmd, input logic [15:0] len, input logic [7:0] b);
        logic [15:0] len_field;
        len_field = len + LEN_FIELD_ADD;
        if (cmd == CMD_START)
        begin
            frame_open = 1'b0;
            bytes_left = '0;
            crc_acc    = CRC_INIT;
            if ({1'b0, len} + FRAME_OVERHEAD > {1'b0, limit_reg})
                push_word(8'h00, 1'b1, 1'b1);
            else
            begin
                emit_byte(SYNC0_BYTE);
                emit_byte(SYNC1_BYTE);
                emit_byte(len_field[15:8]);
                emit_byte(len_field[7:0]);
                emit_byte(ZERO_BYTE);
                if (len == 16'd0)
                    close_frame();
                else
                begin
                    bytes_left = len;
                    frame_open = 1'b1;
                end
            end
        end
        else if (frame_open)
        begin
            emit_byte(b);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0)
                close_frame();
        end
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic send_word(input logic cmd, input logic [15:0] len, input logic [7:0] b);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {b, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        busy_words++;
        model_word(cmd, len, b);
    endtask

    task automatic send_start(input logic [15:0] len);
        send_word(CMD_START, len, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(CMD_PAYLOAD, 16'($urandom), b);
    endtask

    task automatic send_frame(input logic [15:0] len);
        send_start(len);
        repeat (len) send_byte(8'($urandom));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_reg = v;
    endtask

    // ---------------- tests ----------------

    task automatic test_basic_frames();
        send_start(16'd0);
        send_start(16'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h3C);           // stray payload, no frame open
        send_byte(8'hC3);
        send_start(16'd2);
        send_byte(8'h5A);
        send_frame(16'd1);          // aborts the open frame
    endtask

    task automatic test_size_limit();
        send_start(16'd504);        // exactly 512
        send_byte(8'h01);
        send_start(16'd505);        // one over
        send_byte(8'h22);
        send_byte(8'h33);
        send_start(16'hFFFC);
        write_limit(16'd0);
        send_start(16'd0);
        write_limit(16'd8);
        send_start(16'd0);
        send_start(16'd1);
        send_byte(8'h11);
        write_limit(16'd9);
        send_start(16'd1);
        send_byte(8'h80);
        write_limit(16'hFFFF);
        send_start(16'd65527);
        send_byte(8'h7E);
        send_start(16'd65528);
        send_start(16'd65532);
        write_limit(MAX_FRAME_RESET);
    endtask

    task automatic test_backpressure();
        stall_sink = 1'b1;
        send_frame(16'd24);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int pick;
        int n;
        int next_cfg;
        next_cfg   = 60;
        busy_words = 0;
        while (busy_words < RANDOM_WORDS)
        begin
            no_idle = (busy_words >= RANDOM_WORDS - TAIL_WORDS);
            if (!no_idle && busy_words >= next_cfg)
            begin
                next_cfg += 60;
                case ($urandom_range(0, 4))
                    0: write_limit(16'($urandom_range(8, 40)));
                    1: write_limit(16'($urandom));
                    2: write_limit(16'hFFFF);
                    3: write_limit(MAX_FRAME_RESET);
                    default: write_limit(16'($urandom_range(0, 12)));
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(16'($urandom_range(0, 24)));
            else if (pick < 82)
            begin
                n = $urandom_range(1, 24);
                send_start(16'(n));
                repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom));
            end
            else if (pick < 90)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            else
            begin
                send_start(16'($urandom));
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            end
        end
    endtask

    // ---------------- output side ----------------

    initial
    begin : sink
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_sink)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_sink = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_words
        frame_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, got data %02h last %b rej %b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatches++;
            end
            else
            begin
                w = expected_bytes.pop_front();
                if (m_tdata !== w.data)
                begin
                    $display("%0t: frame_byte expected %02h got %02h", $time, w.data, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== w.last)
                begin
                    $display("%0t: end_of_frame expected %b got %b", $time, w.last, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== w.rej)
                begin
                    $display("%0t: rejected expected %b got %b", $time, w.rej, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout", $time);
                $display("tb_crc_frame_builder NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_frames();
        test_size_limit();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("tb_crc_frame_builder OK");
        else
            $display("tb_crc_frame_builder NOT OK");
        $finish;
    end

endmodule

@@ crc_frame_builder.f @@
rtl/core/crcfb_pkg.sv
rtl/core/crcfb_front.sv
rtl/core/crcfb_queue.sv
rtl/core/crcfb_back.sv
rtl/core/crc_frame_builder.sv
tb/tb_crc_frame_builder.sv
